### src/sine_lfo_flanger_assert.svh
// assertion macros for the flanger rtl
// expects clk and rst_n in the scope of the including module
`ifndef SINE_LFO_FLANGER_ASSERT_SVH
`define SINE_LFO_FLANGER_ASSERT_SVH

// same-cycle implication
`define FLG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flanger assertion failed");

// next-cycle implication
`define FLG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flanger assertion failed");

`endif

### src/flg_pkg.sv
// types, constants and the quarter-wave sine table for the flanger
// no dependencies; used by every flanger module
package flg_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DLY_W    = 8;
  localparam int OP_W     = 18;
  localparam int PROD_W   = 2 * OP_W;

  localparam int BASE_DELAY_W = 7;
  localparam int LFO_STEP_W   = 31;
  localparam int MIX_GAIN_W   = 16;
  localparam int CFG_DATA_W   = 31;
  localparam int CFG_IDX_W    = 2;

  localparam logic [BASE_DELAY_W-1:0] BASE_DELAY_RST = 7'd11;
  localparam logic [LFO_STEP_W-1:0]   LFO_STEP_RST   = 31'd389566;
  localparam logic [MIX_GAIN_W-1:0]   MIX_GAIN_RST   = 16'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_DELAY = 2'd0,
    CFG_LFO_STEP   = 2'd1,
    CFG_MIX_GAIN   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DLY,
    ST_ADDR,
    ST_MIX,
    ST_DONE
  } flg_state_t;

  typedef struct packed {
    logic take;
    logic st_dly;
    logic st_addr;
    logic st_mix;
    logic fire;
  } flg_ctrl_t;

  // quarter-wave table of SQ_N + 1 entries, SQ_N is a power of two
  localparam int SQ_N    = 256;
  localparam int SQ_BITS = $clog2(SQ_N);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [1:12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  typedef logic [SAMPLE_W-2:0] sine_tab_t [0:SQ_N];

  function automatic logic [SAMPLE_W-2:0] sine_entry(input int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    logic [63:0] v;
    x    = (64'(k) * HALF_PI_Q30) / SQ_N;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[SAMPLE_W-2:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t t;
    for (int k = 0; k <= SQ_N; k++) begin
      t[k] = sine_entry(k);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### src/flg_sine.sv
// lfo sine lookup: quadrant mirroring of the quarter-wave table, registered
// depends on flg_pkg
module flg_sine (
  input  logic                                  clk,
  input  logic [31:0]                           phase,
  output logic signed [flg_pkg::SAMPLE_W-1:0]   sine_r
);
  import flg_pkg::*;

  logic [1:0]                quad;
  logic [SQ_BITS-1:0]        idx;
  logic [SQ_BITS:0]          tab_idx;
  logic signed [SAMPLE_W-1:0] mag;
  logic signed [SAMPLE_W-1:0] sine_nxt;

  assign quad = phase[31:30];
  assign idx  = phase[29:30-SQ_BITS];

  always_comb begin
    if (quad[0]) begin
      tab_idx = (SQ_BITS+1)'(SQ_N) - {1'b0, idx};
    end else begin
      tab_idx = {1'b0, idx};
    end
    mag      = signed'({1'b0, SINE_TAB[tab_idx]});
    sine_nxt = quad[1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
  end

endmodule

### src/flg_mul.sv
// shared signed multiplier with registered product, used for delay and gain
// depends on flg_pkg
module flg_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [flg_pkg::OP_W-1:0]       op_a,
  input  logic signed [flg_pkg::OP_W-1:0]       op_b,
  output logic signed [flg_pkg::PROD_W-1:0]     prod_r
);
  import flg_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= op_a * op_b;
    end
  end

endmodule

### src/flg_dline.sv
// delay line memory, one write port and one registered read port
// depends on flg_pkg
module flg_dline #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic [flg_pkg::SAMPLE_W-1:0]       wdata,
  input  logic                               re,
  input  logic [AW-1:0]                      raddr,
  output logic [flg_pkg::SAMPLE_W-1:0]       rdata_r
);
  import flg_pkg::*;

  logic [SAMPLE_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

### src/flg_ctrl.sv
// sequencer for the flanger: handshakes and step flags for the shared unit
// depends on flg_pkg and sine_lfo_flanger_assert.svh
`include "sine_lfo_flanger_assert.svh"

module flg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output logic                out_valid,
  output flg_pkg::flg_ctrl_t  ctrl
);
  import flg_pkg::*;

  flg_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    ctrl         = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_DLY;
        end
      end
      ST_DLY: begin
        ctrl.st_dly = 1'b1;
        state_nxt   = ST_ADDR;
      end
      ST_ADDR: begin
        ctrl.st_addr = 1'b1;
        state_nxt    = ST_MIX;
      end
      ST_MIX: begin
        ctrl.st_mix = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          ctrl.fire = 1'b1;
          in_ready  = 1'b1;
          state_nxt = in_valid ? ST_DLY : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    ctrl.take = in_valid && in_ready;
    if (ctrl.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  `FLG_ASSERT_NEXT(a_take_starts, in_valid && in_ready, state_r == ST_DLY)
  `FLG_ASSERT_IMPL(a_stall_blocks, out_valid_r && !out_ready && state_r != ST_IDLE, !in_ready)
  `FLG_ASSERT_NEXT(a_fire_valid, ctrl.fire, out_valid_r)
  `FLG_ASSERT_NEXT(a_mix_to_done, state_r == ST_MIX, state_r == ST_DONE)

endmodule

### src/sine_lfo_flanger.sv
// channel | signals                              | beat when
// input   | in_valid in_ready in_sample_in       | in_valid && in_ready
// output  | out_valid out_ready out_sample_out   | out_valid && out_ready
// config  | cfg_we cfg_index cfg_wdata           | cfg_we
// one sample steps in turn through lfo delay product, delay line read, gain product, mix
// the shared multiplier and the single delay line read port make these steps run one after another
// a new beat is taken in the mix cycle when the output register is free
// reset is synchronous and active low; the delay line has no reset
// a stalled output holds the block in its mix cycle; an idle block still takes a beat
module sine_lfo_flanger #(
  parameter int DELAY_DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [flg_pkg::SAMPLE_W-1:0]      in_sample_in,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [flg_pkg::SAMPLE_W-1:0]      out_sample_out,
  input  logic                                     cfg_we,
  input  logic [flg_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [flg_pkg::CFG_DATA_W-1:0]           cfg_wdata
);
  import flg_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SW = $clog2(DELAY_DEPTH + 1);
  localparam int CW = (SW > DLY_W) ? SW : DLY_W;
  localparam int RW = CW + 1;
  localparam logic [RW-1:0] DEPTH_RW = RW'(DELAY_DEPTH);
  localparam int SUM_W = SAMPLE_W + 4;

  logic [BASE_DELAY_W-1:0] base_delay_r;
  logic [LFO_STEP_W-1:0]   lfo_step_r;
  logic [MIX_GAIN_W-1:0]   mix_gain_r;
  logic [31:0]             lfo_phase_r;
  logic [AW-1:0]           wp_r;
  logic [SW-1:0]           seen_r;
  logic                    hit_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;

  flg_ctrl_t                  ctrl;
  logic signed [SAMPLE_W-1:0] sine_r;
  logic signed [OP_W-1:0]     op_a, op_b;
  logic signed [PROD_W-1:0]   prod_r;
  logic [SAMPLE_W-1:0]        rdata_r;

  logic [DLY_W-1:0]     dly;
  logic [RW-1:0]        dly_ext, wp_ext, seen_ext, rd_full;
  logic                 hit;
  logic [AW-1:0]        raddr;
  logic signed [SUM_W-1:0] mix_sum;
  logic signed [SAMPLE_W-1:0] y_nxt;

  flg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctrl      (ctrl)
  );

  flg_sine u_sine (
    .clk    (clk),
    .phase  (lfo_phase_r),
    .sine_r (sine_r)
  );

  always_comb begin
    if (ctrl.st_mix) begin
      op_a = signed'(OP_W'(mix_gain_r));
      op_b = OP_W'(signed'(rdata_r));
    end else begin
      op_a = signed'(OP_W'(base_delay_r));
      op_b = OP_W'(sine_r) + signed'(OP_W'(32768));
    end
  end

  flg_mul u_mul (
    .clk    (clk),
    .en     (ctrl.st_dly || ctrl.st_mix),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  assign dly      = prod_r[15+DLY_W-1:15];
  assign dly_ext  = RW'(dly);
  assign wp_ext   = RW'(wp_r);
  assign seen_ext = RW'(seen_r);
  assign hit      = dly_ext < seen_ext;
  assign rd_full  = (wp_ext >= dly_ext) ? (wp_ext - dly_ext) : (wp_ext + DEPTH_RW - dly_ext);
  assign raddr    = rd_full[AW-1:0];

  flg_dline #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_dline (
    .clk     (clk),
    .we      (ctrl.st_dly),
    .waddr   (wp_r),
    .wdata   (x_r),
    .re      (ctrl.st_addr && hit),
    .raddr   (raddr),
    .rdata_r (rdata_r)
  );

  always_comb begin
    mix_sum = SUM_W'(x_r) + SUM_W'(prod_r[PROD_W-1:16]);
    if (!hit_r) begin
      y_nxt = x_r;
    end else if (mix_sum > SUM_W'(32767)) begin
      y_nxt = 16'sh7fff;
    end else if (mix_sum < -SUM_W'(32768)) begin
      y_nxt = 16'sh8000;
    end else begin
      y_nxt = mix_sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_delay_r <= BASE_DELAY_RST;
      lfo_step_r   <= LFO_STEP_RST;
      mix_gain_r   <= MIX_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_DELAY: base_delay_r <= cfg_wdata[BASE_DELAY_W-1:0];
        CFG_LFO_STEP:   lfo_step_r   <= cfg_wdata[LFO_STEP_W-1:0];
        CFG_MIX_GAIN:   mix_gain_r   <= cfg_wdata[MIX_GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfo_phase_r <= '0;
      wp_r        <= '0;
      seen_r      <= '0;
    end else if (ctrl.st_addr) begin
      lfo_phase_r <= lfo_phase_r + 32'(lfo_step_r);
      wp_r        <= (wp_r == AW'(DELAY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (seen_r != SW'(DELAY_DEPTH)) begin
        seen_r <= seen_r + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      x_r <= in_sample_in;
    end
    if (ctrl.st_addr) begin
      hit_r <= hit;
    end
    if (ctrl.fire) begin
      y_r <= y_nxt;
    end
  end

  assign out_sample_out = y_r;

endmodule

### sim/sine_lfo_flanger_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sine_lfo_flanger: directed and random sample streams
// predicts every flanged sample from its own lfo, sine table and delay line
// depends on flg_pkg and the sine_lfo_flanger rtl
module sine_lfo_flanger_tb;
  import flg_pkg::*;

  localparam int LINE_DEPTH = 256;
  localparam int QUARTER_N = 256;
  localparam logic [63:0] HALF_PI = 64'd1686629713;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;
  localparam int RAND_PER_PHASE = 128;
  localparam int SAT_HI = 32767;
  localparam int SAT_LO = -32768;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int beats_sent = 0;
  int beats_checked = 0;

  int sine_q15 [0:QUARTER_N];
  logic signed [SAMPLE_W-1:0] dly_mem [0:LINE_DEPTH-1];
  logic [DLY_W-1:0] wr_ptr;
  int seen_cnt;
  logic [31:0] phase_acc;
  logic [BASE_DELAY_W-1:0] m_base_delay;
  logic [LFO_STEP_W-1:0] m_lfo_step;
  logic [MIX_GAIN_W-1:0] m_mix_gain;
  logic signed [SAMPLE_W-1:0] flanged_q [$];
  logic signed [SAMPLE_W-1:0] exp_sample;

  sine_lfo_flanger uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample_in(in_sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_sample_out(out_sample_out),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // q30 taylor series, rounded to q15
  function automatic int quarter_sine(input int k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned v;
    longint acc;
    x = (64'(k) * HALF_PI) / 64'(QUARTER_N);
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    v = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return int'(v);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] flange_sample(
    input logic signed [SAMPLE_W-1:0] x
  );
    int s;
    int d;
    int y;
    int idx;
    logic [DLY_W-1:0] rd;
    longint prod;
    idx = int'(phase_acc[29:22]);
    if (phase_acc[30]) begin
      s = sine_q15[QUARTER_N - idx];
    end else begin
      s = sine_q15[idx];
    end
    if (phase_acc[31]) begin
      s = -s;
    end
    d = (int'(m_base_delay) * (32768 + s)) >> 15;
    // current sample goes in before the tap is read
    dly_mem[wr_ptr] = x;
    y = x;
    if (d < seen_cnt) begin
      rd = wr_ptr - DLY_W'(d);
      prod = longint'(m_mix_gain) * longint'(dly_mem[rd]);
      y = y + int'(prod >>> 16);
      if (y > SAT_HI) begin
        y = SAT_HI;
      end
      if (y < SAT_LO) begin
        y = SAT_LO;
      end
    end
    wr_ptr = wr_ptr + 1'b1;
    if (seen_cnt < LINE_DEPTH) begin
      seen_cnt++;
    end
    phase_acc = phase_acc + {1'b0, m_lfo_step};
    return y[SAMPLE_W-1:0];
  endfunction

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      beats_checked++;
      if (flanged_q.size() == 0) begin
        $display("%0t: sample_out beat with nothing pending, expected none actual %0d",
                 $time, out_sample_out);
        mismatches++;
      end else begin
        exp_sample = flanged_q.pop_front();
        if (out_sample_out !== exp_sample) begin
          $display("%0t: sample_out mismatch, expected %0d actual %0d",
                   $time, exp_sample, out_sample_out);
          mismatches++;
        end
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= value;
    do @(posedge clk); while (!in_ready);
    flanged_q.push_back(flange_sample(value));
    beats_sent++;
  endtask

  task automatic wait_results(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (flanged_q.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // raw words carry junk above each register's width
  task automatic set_config(
    input logic [CFG_DATA_W-1:0] raw_base,
    input logic [CFG_DATA_W-1:0] raw_step,
    input logic [CFG_DATA_W-1:0] raw_mix
  );
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [CFG_DATA_W-1:0] data_list [4];
    idx_list = '{CFG_BASE_DELAY, CFG_LFO_STEP, CFG_MIX_GAIN, CFG_UNUSED};
    data_list = '{raw_base, raw_step, raw_mix, CFG_DATA_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_wdata <= data_list[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_base_delay = raw_base[BASE_DELAY_W-1:0];
    m_lfo_step = raw_step[LFO_STEP_W-1:0];
    m_mix_gain = raw_mix[MIX_GAIN_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SAMPLE_W'($urandom_range(63) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // reset defaults: first twelve beats pass through, then the tap kicks in
  task automatic test_startup();
    logic signed [SAMPLE_W-1:0] vals [16];
    vals = '{16'sh0000, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000, 16'sh5555,
             16'shaaaa, 16'sh0064, 16'shff9c, 16'sh04d2, 16'shef1f, 16'sh4000,
             16'sh2000, 16'she000, 16'sh7fff, 16'sh8000};
    foreach (vals[i]) begin
      send_sample(vals[i]);
    end
    wait_results(DRAIN_CYCLES);
  endtask

  // zero delay mixes a sample with itself at full gain
  task automatic test_self_mix();
    logic signed [SAMPLE_W-1:0] vals [5];
    vals = '{16'sh7fff, 16'sh8000, 16'shffff, 16'sh0001, 16'sh4000};
    set_config({24'hffffff, 7'd0}, 31'd0, {15'h7fff, 16'hffff});
    foreach (vals[i]) begin
      send_sample(vals[i]);
    end
    wait_results(DRAIN_CYCLES);
  endtask

  // widest swing, fastest lfo, then quadrant stepping at full gain
  task automatic test_wide_swing();
    set_config({24'h000000, 7'd127}, 31'h7fffffff, {15'h0000, 16'h0000});
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh1234);
    wait_results(DRAIN_CYCLES);
    set_config({24'h5a5a5a, 7'd127}, 31'h40000000, {15'h2aaa, 16'hffff});
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'shc000);
    send_sample(16'sh3fff);
    wait_results(DRAIN_CYCLES);
  endtask

  task automatic test_random_phase(input int s_idle, input int r_idle);
    logic [CFG_DATA_W-1:0] raw_base;
    logic [CFG_DATA_W-1:0] raw_step;
    logic [CFG_DATA_W-1:0] raw_mix;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_results(DRAIN_CYCLES);
      raw_base = CFG_DATA_W'($urandom);
      raw_step = CFG_DATA_W'($urandom);
      raw_mix = CFG_DATA_W'($urandom);
      case ($urandom_range(5))
        0: raw_base[BASE_DELAY_W-1:0] = '0;
        1: raw_base[BASE_DELAY_W-1:0] = '1;
        default: ;
      endcase
      case ($urandom_range(5))
        0: raw_step = '0;
        1: raw_step = '1;
        2: raw_step = CFG_DATA_W'($urandom_range(2000000));
        default: ;
      endcase
      case ($urandom_range(5))
        0: raw_mix[MIX_GAIN_W-1:0] = '0;
        1: raw_mix[MIX_GAIN_W-1:0] = '1;
        default: ;
      endcase
      set_config(raw_base, raw_step, raw_mix);
      for (int i = 0; i < RAND_PER_PHASE / 4; i++) begin
        if ($urandom_range(39) == 0) begin
          wait_results(0);
        end
        send_sample(random_sample());
      end
    end
    wait_results(DRAIN_CYCLES);
  endtask

  initial begin
    for (int k = 0; k <= QUARTER_N; k++) begin
      sine_q15[k] = quarter_sine(k);
    end
    foreach (dly_mem[i]) begin
      dly_mem[i] = '0;
    end
    wr_ptr = '0;
    seen_cnt = 0;
    phase_acc = '0;
    m_base_delay = BASE_DELAY_RST;
    m_lfo_step = LFO_STEP_RST;
    m_mix_gain = MIX_GAIN_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_startup();
    test_self_mix();
    test_wide_swing();
    test_random_phase(15, 87);
    test_random_phase(87, 15);
    test_random_phase(0, 0);

    $display("%0d samples sent and %0d checked over reset, extreme and random settings",
             beats_sent, beats_checked);
    $display("sender and receiver stalls mixed both ways and off, with full drain pauses");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
